// ===== sv/bauls_pkg.sv =====
// Package for the banked unaligned load/store unit: opcodes, sizes and state type.
`timescale 1ns / 1ps

package bauls_pkg;

    localparam int BANK_ROWS_DEF = 64;
    localparam int NUM_BANKS     = 4;
    localparam int BANK_W        = 16;

    localparam logic [2:0] OP_LOAD_WORD  = 3'd0;
    localparam logic [2:0] OP_LOAD_HALF  = 3'd1;
    localparam logic [2:0] OP_LOAD_BYTE  = 3'd2;
    localparam logic [2:0] OP_STORE_WORD = 3'd3;
    localparam logic [2:0] OP_STORE_HALF = 3'd4;
    localparam logic [2:0] OP_STORE_BYTE = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== sv/banked_unaligned_load_store.sv =====
// Banked unaligned big-endian load/store unit: four 16-bit banks with read-modify-write.
`timescale 1ns / 1ps

// On acceptance of a request the four banks are read at the rows the access touches
// (one synchronous read port per bank); in the execute state the bytes are picked out
// for a load or merged and written back for a store. A new request is taken only once
// the previous one has left execute; a load waits in execute only while an earlier load
// result still sits unread in the output register. The banks read as zero after reset
// through a valid bit per row and bank, so no clearing pass is needed.
module banked_unaligned_load_store #(
    parameter int BANK_ROWS = bauls_pkg::BANK_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  byte_address,
    input  logic [31:0] write_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_value
);

    localparam int RW = $clog2(BANK_ROWS);
    localparam int NB = bauls_pkg::NUM_BANKS;
    localparam int BW = bauls_pkg::BANK_W;

    bauls_pkg::state_t state_reg, state_next;

    logic          in_fire;
    logic          exec_fire;
    logic          is_load;
    logic          is_store;

    logic [2:0]    op_reg;
    logic [7:0]    addr_reg;
    logic [31:0]   wval_reg;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   read_value_reg, read_value_next;

    logic [RW-1:0] row_in [NB];
    logic          touch_in [NB];
    logic [RW-1:0] row_reg [NB];
    logic          touch_reg [NB];

    logic [BW-1:0] rd_data [NB];
    logic [BW-1:0] wr_data [NB];
    logic [NB-1:0] wr_en;

    // request decode
    assign is_load  = (op_reg == bauls_pkg::OP_LOAD_WORD) || (op_reg == bauls_pkg::OP_LOAD_HALF)
                   || (op_reg == bauls_pkg::OP_LOAD_BYTE);
    assign is_store = (op_reg == bauls_pkg::OP_STORE_WORD)
                   || (op_reg == bauls_pkg::OP_STORE_HALF)
                   || (op_reg == bauls_pkg::OP_STORE_BYTE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bauls_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bauls_pkg::ST_EXEC;
                end
            end
            bauls_pkg::ST_EXEC:
            begin
                if (!(is_load && out_valid_reg && !out_ready))
                begin
                    state_next = bauls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bauls_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            bauls_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bauls_pkg::ST_EXEC:
            begin
                exec_fire = !(is_load && out_valid_reg && !out_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire = in_valid && in_ready;

    // rows per bank: halfwords touched are consecutive, so each bank is hit at most once
    always_comb
    begin
        logic [8:0] last_b;
        logic [7:0] h0;
        logic [7:0] span;
        logic [1:0] d;
        logic [7:0] h;
        case (opcode)
            bauls_pkg::OP_LOAD_WORD, bauls_pkg::OP_STORE_WORD:
                last_b = {1'b0, byte_address} + 9'd3;
            bauls_pkg::OP_LOAD_HALF, bauls_pkg::OP_STORE_HALF:
                last_b = {1'b0, byte_address} + 9'd1;
            default:
                last_b = {1'b0, byte_address};
        endcase
        h0   = {1'b0, byte_address[7:1]};
        span = last_b[8:1] - h0;
        for (int k = 0; k < NB; k++)
        begin
            d           = 2'(k) - h0[1:0];
            h           = h0 + {6'd0, d};
            row_in[k]   = RW'(h[7:2]);
            touch_in[k] = ({6'd0, d} <= span);
        end
    end

    // bank memories
    for (genvar k = 0; k < NB; k++)
    begin : g_bank
        logic [BW-1:0]        mem [BANK_ROWS];
        logic [BANK_ROWS-1:0] valid_reg;
        logic [BW-1:0]        rdata_reg;
        logic                 rvalid_reg;

        always_ff @(posedge clk)
        begin
            if (in_fire)
            begin
                rdata_reg <= mem[row_in[k]];
            end
            if (wr_en[k])
            begin
                mem[row_reg[k]] <= wr_data[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg  <= '0;
                rvalid_reg <= 1'b0;
            end
            else
            begin
                if (in_fire)
                begin
                    rvalid_reg <= valid_reg[row_in[k]];
                end
                if (wr_en[k])
                begin
                    valid_reg[row_reg[k]] <= 1'b1;
                end
            end
        end

        assign rd_data[k] = rvalid_reg ? rdata_reg : '0;
    end

    // request registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= opcode;
            addr_reg <= byte_address;
            wval_reg <= write_value;
            for (int k = 0; k < NB; k++)
            begin
                row_reg[k]   <= row_in[k];
                touch_reg[k] <= touch_in[k];
            end
        end
    end

    // byte select for loads, byte-masked merge for stores
    always_comb
    begin
        logic [8:0] badr;
        logic [1:0] bk;
        logic [7:0] lb [4];
        logic [7:0] sb [4];
        logic [2:0] nbytes;
        for (int k = 0; k < NB; k++)
        begin
            wr_data[k] = rd_data[k];
        end
        case (op_reg)
            bauls_pkg::OP_LOAD_WORD, bauls_pkg::OP_STORE_WORD: nbytes = 3'd4;
            bauls_pkg::OP_LOAD_HALF, bauls_pkg::OP_STORE_HALF: nbytes = 3'd2;
            default:                                           nbytes = 3'd1;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            case (nbytes)
                3'd4:    sb[i] = wval_reg[8*(3-i) +: 8];
                3'd2:    sb[i] = (i == 0) ? wval_reg[15:8] : wval_reg[7:0];
                default: sb[i] = wval_reg[7:0];
            endcase
            badr  = {1'b0, addr_reg} + 9'(i);
            bk    = badr[2:1];
            lb[i] = badr[0] ? rd_data[bk][7:0] : rd_data[bk][15:8];
            if (3'(i) < nbytes)
            begin
                if (badr[0])
                begin
                    wr_data[bk][7:0] = sb[i];
                end
                else
                begin
                    wr_data[bk][15:8] = sb[i];
                end
            end
        end
        for (int k = 0; k < NB; k++)
        begin
            wr_en[k] = exec_fire && is_store && touch_reg[k];
        end
        case (nbytes)
            3'd4:    read_value_next = {lb[0], lb[1], lb[2], lb[3]};
            3'd2:    read_value_next = {16'd0, lb[0], lb[1]};
            default: read_value_next = {24'd0, lb[0]};
        endcase
    end

    assign out_valid_next = (exec_fire && is_load) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (exec_fire && is_load)
        begin
            read_value_reg <= read_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bauls_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == bauls_pkg::ST_EXEC)
        else $error("accepted request did not enter execute");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bauls_pkg::ST_EXEC && exec_fire |=> state_reg == bauls_pkg::ST_IDLE)
        else $error("execute did not complete");

    a_write_only_store: assert property (@(posedge clk) disable iff (!rst_n)
        (|wr_en) |-> (state_reg == bauls_pkg::ST_EXEC && is_store))
        else $error("bank write outside a store");

    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bauls_pkg::ST_EXEC) && $past(is_load))
        else $error("result without a load");
`endif

endmodule
